@@ rtl/gtm_pkg.sv @@
// Shared constants and types for the Goertzel tone magnitude block.
`timescale 1ns / 1ps
package gtm_pkg;

   localparam int STATE_WIDTH_DEF = 40;
   localparam int SAMPLE_W        = 16;
   localparam int REQ_DATA_W      = 16;
   localparam int COEF_W          = 18;
   localparam int FRAC_W          = 16;
   localparam int MAG_W           = 42;
   localparam int RSP_DATA_W      = 48;
   localparam int CSR_INDEX_W     = 2;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN      = 2'd2;

   localparam logic signed [COEF_W-1:0] FEEDBACK_RESET = 18'sd0;
   localparam logic signed [COEF_W-1:0] COS_RESET      = 18'sd65536;
   localparam logic signed [COEF_W-1:0] SIN_RESET      = 18'sd0;

   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/gtm_front.sv @@
// Front end: sample intake, coefficient registers, Goertzel recurrence and bin terms.
`timescale 1ns / 1ps
module gtm_front #(
   parameter int STATE_WIDTH = gtm_pkg::STATE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gtm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   input  logic                                csr_we,
   input  logic [gtm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gtm_pkg::COEF_W-1:0]          csr_wdata,
   input  gtm_pkg::queue_status_type           q_status,
   output logic                                q_push,
   output logic [2*(STATE_WIDTH+3)-1:0]        q_data
);
   import gtm_pkg::*;

   localparam int W   = STATE_WIDTH;
   localparam int L   = W / 2;
   localparam int HW  = W - L;
   localparam int MB  = HW + 1;
   localparam int PRW = COEF_W + MB;
   localparam int PW  = W + COEF_W;
   localparam int QW  = PW - FRAC_W;
   localparam int EW  = W + 3;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_M0   = 2'd1;
   localparam logic [1:0] S_M1   = 2'd2;
   localparam logic [1:0] S_M2   = 2'd3;

   localparam logic [1:0] PH_RECUR = 2'd0;
   localparam logic [1:0] PH_RE    = 2'd1;
   localparam logic [1:0] PH_IM    = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic                       fin_ff, fin_in;
   logic [1:0]                 phase_ff, phase_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       last_ff, last_in;
   logic signed [W-1:0]        s1_ff, s1_in, s2_ff, s2_in;
   logic signed [PRW-1:0]      prod_ff, prod_in;
   logic signed [PW-1:0]       acc_ff, acc_in;
   logic signed [EW-1:0]       re_ff, re_in;
   logic signed [COEF_W-1:0]   fb_ff, fb_in, cos_ff, cos_in, sin_ff, sin_in;

   logic signed [COEF_W-1:0]   coef;
   logic signed [MB-1:0]       lo_ext, hi_ext, mul_b;
   logic signed [PRW-1:0]      mul_p;
   logic signed [PW-1:0]       prod_ext, acc_sum;
   logic signed [QW-1:0]       q;
   logic signed [EW-1:0]       q_e, s2_e, x_e, sum, re_val, im_val;
   logic                       fits;
   logic signed [W-1:0]        sat;

   always_comb begin
      case (phase_ff)
         PH_RECUR: coef = fb_ff;
         PH_RE:    coef = cos_ff;
         PH_IM:    coef = sin_ff;
         default:  coef = fb_ff;
      endcase
   end

   assign lo_ext   = {{(MB-L){1'b0}}, s1_ff[L-1:0]};
   assign hi_ext   = {s1_ff[W-1], s1_ff[W-1:L]};
   assign mul_b    = (state_ff == S_M0 && !fin_ff) ? lo_ext : hi_ext;
   assign mul_p    = coef * mul_b;
   assign prod_ext = {{(PW-PRW){prod_ff[PRW-1]}}, prod_ff};
   assign acc_sum  = acc_ff + (prod_ext <<< L);
   assign q        = acc_ff[PW-1:FRAC_W];
   assign q_e      = {{(EW-QW){q[QW-1]}}, q};
   assign s2_e     = {{(EW-W){s2_ff[W-1]}}, s2_ff};
   assign x_e      = {{(EW-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
   assign sum      = x_e + q_e - s2_e;
   assign fits     = (&sum[EW-1:W-1]) | ~(|sum[EW-1:W-1]);
   assign sat      = fits ? sum[W-1:0]
                   : (sum[EW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
   assign re_val   = q_e - s2_e;
   assign im_val   = -q_e;

   assign req_tready = (state_ff == S_IDLE) && !fin_ff && !q_status.full;
   assign q_data     = {re_ff, im_val};

   always_comb begin
      state_in  = state_ff;
      fin_in    = 1'b0;
      phase_in  = phase_ff;
      sample_in = sample_ff;
      last_in   = last_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      re_in     = re_ff;
      q_push    = 1'b0;
      if (fin_ff) begin
         // fin_ff marks the closing step of a multiply pass
         case (phase_ff)
            PH_RECUR: begin
               s2_in = s1_ff;
               s1_in = sat;
               if (last_ff) begin
                  phase_in = PH_RE;
                  state_in = S_M0;
               end else begin
                  state_in = S_IDLE;
               end
            end
            PH_RE: begin
               re_in    = re_val;
               phase_in = PH_IM;
               state_in = S_M0;
            end
            PH_IM: begin
               q_push   = 1'b1;
               s1_in    = '0;
               s2_in    = '0;
               phase_in = PH_RECUR;
               state_in = S_IDLE;
            end
            default: state_in = S_IDLE;
         endcase
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  sample_in = req_tdata;
                  last_in   = req_tlast;
                  phase_in  = PH_RECUR;
                  state_in  = S_M0;
               end
            end
            S_M0: begin
               prod_in  = mul_p;
               state_in = S_M1;
            end
            S_M1: begin
               acc_in   = prod_ext;
               prod_in  = mul_p;
               state_in = S_M2;
            end
            S_M2: begin
               acc_in   = acc_sum;
               fin_in   = 1'b1;
               state_in = S_IDLE;
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_comb begin
      fb_in  = fb_ff;
      cos_in = cos_ff;
      sin_in = sin_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FEEDBACK: fb_in  = csr_wdata;
            CSR_COS:      cos_in = csr_wdata;
            CSR_SIN:      sin_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff   <= 1'b0;
         phase_ff <= PH_RECUR;
         last_ff  <= 1'b0;
         s1_ff    <= '0;
         s2_ff    <= '0;
         fb_ff    <= FEEDBACK_RESET;
         cos_ff   <= COS_RESET;
         sin_ff   <= SIN_RESET;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         fb_ff    <= fb_in;
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      re_ff     <= re_in;
   end

endmodule

@@ rtl/gtm_queue.sv @@
// Small register queue carrying bin terms from the front end to the magnitude unit.
`timescale 1ns / 1ps
module gtm_queue #(
   parameter int DW    = 2 * (gtm_pkg::STATE_WIDTH_DEF + 3),
   parameter int DEPTH = gtm_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [DW-1:0]             push_data,
   input  logic                      pop,
   output gtm_pkg::queue_status_type status,
   output logic [DW-1:0]             rd_data
);
   import gtm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DW-1:0]    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/gtm_back.sv @@
// Back end: sum of squares, bit-pair square root and the result register.
`timescale 1ns / 1ps
module gtm_back #(
   parameter int STATE_WIDTH = gtm_pkg::STATE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gtm_pkg::queue_status_type         q_status,
   input  logic [2*(STATE_WIDTH+3)-1:0]      q_data,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gtm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import gtm_pkg::*;

   localparam int EW  = STATE_WIDTH + 3;
   localparam int AW  = EW;
   localparam int H   = (AW + 1) / 2;
   localparam int NW  = 2 * AW + 2;
   localparam int RW  = NW / 2;
   localparam int RMW = RW + 2;
   localparam int CW  = $clog2(RW);
   localparam int XW  = (RW > MAG_W) ? RW : MAG_W;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_SQ   = 2'd1;
   localparam logic [1:0] B_ROOT = 2'd2;
   localparam logic [1:0] B_DONE = 2'd3;

   localparam logic [1:0] SH_NONE  = 2'd0;
   localparam logic [1:0] SH_CROSS = 2'd1;
   localparam logic [1:0] SH_HIGH  = 2'd2;

   localparam logic [2:0] SQ_END = 3'd6;

   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    mr_ff, mr_in, mi_ff, mi_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [2*H-1:0]   prod_ff, prod_in;
   logic [1:0]       sh_ff, sh_in;
   logic [NW-1:0]    acc_ff, acc_in, n_ff, n_in;
   logic [RMW-1:0]   rem_ff, rem_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [CW-1:0]    it_ff, it_in;
   logic             valid_ff, valid_in;
   logic [MAG_W-1:0] mag_ff, mag_in;

   logic signed [EW-1:0] re_e, im_e;
   logic [AW-1:0]        re_abs, im_abs, val;
   logic [H-1:0]         v_lo, v_hi, op_a, op_b;
   logic [1:0]           sh_sel;
   logic [NW-1:0]        prod_n, add;
   logic [RMW+1:0]       rem_sh, trial, diff;
   logic                 ge;
   logic [XW-1:0]        root_x;
   logic [MAG_W-1:0]     mag;
   logic                 load;

   assign re_e   = q_data[2*EW-1:EW];
   assign im_e   = q_data[EW-1:0];
   assign re_abs = re_e[EW-1] ? -re_e : re_e;
   assign im_abs = im_e[EW-1] ? -im_e : im_e;

   assign val  = (cnt_ff < 3'd3) ? mr_ff : mi_ff;
   assign v_lo = val[H-1:0];
   assign v_hi = H'(val >> H);

   always_comb begin
      case (cnt_ff)
         3'd0, 3'd3: begin
            op_a   = v_lo;
            op_b   = v_lo;
            sh_sel = SH_NONE;
         end
         3'd1, 3'd4: begin
            op_a   = v_lo;
            op_b   = v_hi;
            sh_sel = SH_CROSS;
         end
         default: begin
            op_a   = v_hi;
            op_b   = v_hi;
            sh_sel = SH_HIGH;
         end
      endcase
   end

   assign prod_n = NW'(prod_ff);

   always_comb begin
      case (sh_ff)
         SH_NONE:  add = prod_n;
         SH_CROSS: add = prod_n << (H + 1);
         SH_HIGH:  add = prod_n << (2 * H);
         default:  add = '0;
      endcase
   end

   assign rem_sh = {rem_ff, n_ff[NW-1:NW-2]};
   assign trial  = (RMW+2)'({root_ff, 2'b01});
   assign diff   = rem_sh - trial;
   assign ge     = (rem_sh >= trial);

   assign root_x = XW'(root_ff);
   assign mag    = (root_x > XW'(MAG_MAX)) ? MAG_MAX : root_x[MAG_W-1:0];

   assign load       = (state_ff == B_DONE) && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-MAG_W){1'b0}}, mag_ff};

   always_comb begin
      state_in = state_ff;
      mr_in    = mr_ff;
      mi_in    = mi_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      n_in     = n_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      it_in    = it_ff;
      mag_in   = mag_ff;
      q_pop    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               mr_in    = re_abs;
               mi_in    = im_abs;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = B_SQ;
            end
         end
         B_SQ: begin
            if (cnt_ff != 3'd0) begin
               acc_in = acc_ff + add;
            end
            if (cnt_ff == SQ_END) begin
               n_in     = acc_ff + add;
               rem_in   = '0;
               root_in  = '0;
               it_in    = '0;
               state_in = B_ROOT;
            end else begin
               prod_in = op_a * op_b;
               sh_in   = sh_sel;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         B_ROOT: begin
            rem_in  = ge ? diff[RMW-1:0] : rem_sh[RMW-1:0];
            root_in = {root_ff[RW-2:0], ge};
            n_in    = n_ff << 2;
            it_in   = it_ff + 1'b1;
            if (it_ff == CW'(RW - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (load) begin
               mag_in   = mag;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         it_ff    <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         it_ff    <= it_in;
      end
   end

   always_ff @(posedge clock) begin
      mr_ff   <= mr_in;
      mi_ff   <= mi_in;
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      mag_ff  <= mag_in;
   end

endmodule

@@ rtl/goertzel_tone_magnitude_top.sv @@
// Top level of the Goertzel single-bin tone magnitude block.
// Samples enter on req_ (tlast closes a block) and run through the Goertzel
// recurrence with the feedback coefficient at csr index 0; cos and sin terms
// sit at indexes 1 and 2 (signed Q2.16). In the front end each sample uses
// one 18-bit by half-state multiplier twice per coefficient product, then a
// step to saturate and store the state; a block's last sample also forms the
// real and imaginary terms. Those go through a two-entry queue to the back
// end, which takes the entry, forms the sum of squares, runs the
// one-bit-per-cycle square root and then loads rsp_tdata, so it runs
// alongside the next block's samples. Magnitudes saturate at 2^42 - 1.
`timescale 1ns / 1ps
module goertzel_tone_magnitude_top #(
   parameter int STATE_WIDTH = gtm_pkg::STATE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [gtm_pkg::REQ_DATA_W-1:0]   req_tdata,   // [15:0] sample
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gtm_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [41:0] magnitude
   input  logic                             csr_we,
   input  logic [gtm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gtm_pkg::COEF_W-1:0]       csr_wdata
);
   import gtm_pkg::*;

   localparam int QDW = 2 * (STATE_WIDTH + 3);

   queue_status_type q_status;
   logic             q_push, q_pop;
   logic [QDW-1:0]   q_wdata, q_rdata;

   gtm_front #(
      .STATE_WIDTH(STATE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   gtm_queue #(
      .DW    (QDW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .status    (q_status),
      .rd_data   (q_rdata)
   );

   gtm_back #(
      .STATE_WIDTH(STATE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_data     (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/gtm_checker.sv @@
// Port-level checks for the Goertzel tone magnitude block, bound to the top level.
`timescale 1ns / 1ps
module gtm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [gtm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import gtm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:MAG_W] == '0)
      else $error("pad bits of result beat not zero");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample taken while recurrence still busy");

endmodule

bind goertzel_tone_magnitude_top gtm_checker u_gtm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ bench/goertzel_tone_magnitude_checker.sv @@
// Checker for the Goertzel tone magnitude block: predicts each block's magnitude and compares.
`timescale 1ns / 1ps
module goertzel_tone_magnitude_checker #(
   parameter int STATE_WIDTH = gtm_pkg::STATE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [gtm_pkg::REQ_DATA_W-1:0]   req_tdata,   // [15:0] sample
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [gtm_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [41:0] magnitude
   input  logic                             csr_we,
   input  logic [gtm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gtm_pkg::COEF_W-1:0]       csr_wdata,
   output int                               mismatch_count,
   output int                               outstanding,
   output int                               magnitudes_checked
);
   import gtm_pkg::*;

   typedef logic signed [127:0] wide_type;

   logic signed [COEF_W-1:0] coef_feedback;
   logic signed [COEF_W-1:0] coef_cos;
   logic signed [COEF_W-1:0] coef_sin;
   wide_type                 near_state;
   wide_type                 far_state;
   logic [MAG_W-1:0]         magnitude_q[$];
   int                       errors;
   int                       checked;

   function automatic wide_type scale_q16(input wide_type a,
                                          input logic signed [COEF_W-1:0] c);
      wide_type cw;
      cw = c;
      return (a * cw) >>> FRAC_W;
   endfunction

   function automatic wide_type clamp_state(input wide_type v);
      wide_type lim;
      lim = wide_type'(1) <<< (STATE_WIDTH - 1);
      if (v > lim - 1)
         return lim - 1;
      if (v < -lim)
         return -lim;
      return v;
   endfunction

   function automatic logic [MAG_W-1:0] tone_magnitude(input wide_type re, input wide_type im);
      logic [127:0] ure;
      logic [127:0] uim;
      logic [127:0] energy;
      logic [127:0] trial_sq;
      logic [63:0]  root;
      logic [63:0]  trial;
      int           b;
      ure = (re < 0) ? -re : re;
      uim = (im < 0) ? -im : im;
      energy = ure * ure + uim * uim;
      root = '0;
      for (b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         trial_sq = {64'd0, trial} * {64'd0, trial};
         if (trial_sq <= energy)
            root = trial;
      end
      if (root > MAG_MAX)
         return MAG_MAX;
      return root[MAG_W-1:0];
   endfunction

   always @(posedge clock) begin
      wide_type               x;
      wide_type               s;
      wide_type               re;
      wide_type               im;
      logic [RSP_DATA_W-1:0]  want;
      if (reset) begin
         coef_feedback = FEEDBACK_RESET;
         coef_cos = COS_RESET;
         coef_sin = SIN_RESET;
         near_state = '0;
         far_state = '0;
         magnitude_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FEEDBACK: coef_feedback = csr_wdata;
               CSR_COS:      coef_cos = csr_wdata;
               CSR_SIN:      coef_sin = csr_wdata;
               default:      ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (magnitude_q.size() == 0) begin
               errors++;
               $display("%0t: magnitude beat with none pending, expected nothing, got %0d",
                        $time, rsp_tdata);
            end else begin
               want = {{(RSP_DATA_W - MAG_W){1'b0}}, magnitude_q.pop_front()};
               checked++;
               if (rsp_tdata !== want) begin
                  errors++;
                  $display("%0t: magnitude mismatch, expected %0d, got %0d",
                           $time, want, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            x = $signed(req_tdata);
            s = clamp_state(x + scale_q16(near_state, coef_feedback) - far_state);
            far_state = near_state;
            near_state = s;
            if (req_tlast) begin
               re = scale_q16(near_state, coef_cos) - far_state;
               im = -scale_q16(near_state, coef_sin);
               magnitude_q.push_back(tone_magnitude(re, im));
               near_state = '0;
               far_state = '0;
            end
         end
      end
      mismatch_count <= errors;
      outstanding <= magnitude_q.size();
      magnitudes_checked <= checked;
   end

endmodule

@@ bench/tb_goertzel_tone_magnitude_top.sv @@
// Testbench top: drives samples and coefficient writes into the Goertzel block and gives the verdict.
`timescale 1ns / 1ps
module tb_goertzel_tone_magnitude_top;
   import gtm_pkg::*;

   localparam int STATE_W          = STATE_WIDTH_DEF;
   localparam int RESET_CYCLES     = 4;
   localparam int SETTLE_CYCLES    = 80;
   localparam int HOLD_CYCLES      = 400;
   localparam int NUM_SETTINGS     = 9;
   localparam int HOLD_SETTING     = 5;
   localparam int ITEMS_PER_PHASE  = 85;
   localparam int LONG_BLOCK_LEN   = 64;
   localparam int TIMEOUT_NS       = 10_000_000;
   localparam int COEF_MIN         = -131072;
   localparam int COEF_MAX         = 131071;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;    // [15:0] sample
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;         // [41:0] magnitude
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [COEF_W-1:0]       csr_wdata = '0;

   int  mismatch_count;
   int  outstanding;
   int  magnitudes_checked;
   bit  quiet = 1'b0;
   int  hold_requests = 0;
   int  holds_served = 0;
   int  samples_sent = 0;
   int  random_samples = 0;
   int  blocks_sent = 0;
   int  settings_used = 0;

   int  fb_setting [NUM_SETTINGS] = '{0, COEF_MAX, COEF_MIN, 92682, 0, 0, 0, 0, 0};
   int  cos_setting[NUM_SETTINGS] = '{65536, COEF_MIN, COEF_MAX, 46341, 0, 0, 0, 0, 0};
   int  sin_setting[NUM_SETTINGS] = '{0, COEF_MAX, COEF_MIN, 46341, 0, 0, 0, 0, 0};
   logic [15:0] tone_wave[8] = '{16'd30000, 16'd21213, 16'd0, -16'sd21213,
                                 -16'sd30000, -16'sd21213, 16'd0, 16'd21213};

   always #5 clock = ~clock;

   goertzel_tone_magnitude_top #(.STATE_WIDTH(STATE_W)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   goertzel_tone_magnitude_checker #(.STATE_WIDTH(STATE_W)) magnitude_check (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tlast          (req_tlast),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding),
      .magnitudes_checked (magnitudes_checked)
   );

   function automatic int idle_cycles();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 16'($urandom_range(0, 16'hFFFF));
      if (r < 78) begin
         case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
         endcase
      end
      return 16'($urandom_range(0, 255) - 128);
   endfunction

   function automatic int block_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 8);
      if (r < 95)
         return $urandom_range(9, 32);
      return $urandom_range(33, 80);
   endfunction

   task automatic send_sample(input logic [15:0] value, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      if (last)
         blocks_sent++;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_block(input int len);
      int k;
      for (k = 0; k < len; k++)
         send_sample(pick_sample(), k == len - 1);
      random_samples += len;
   endtask

   // hold the sender until every magnitude is back, then let the back end settle
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic load_coefficients(input int fb, input int cs, input int sn,
                                    input bit poke_unused);
      csr_we <= 1'b1;
      csr_index <= CSR_FEEDBACK;
      csr_wdata <= fb[COEF_W-1:0];
      @(posedge clock);
      csr_index <= CSR_COS;
      csr_wdata <= cs[COEF_W-1:0];
      @(posedge clock);
      csr_index <= CSR_SIN;
      csr_wdata <= sn[COEF_W-1:0];
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= COEF_W'($urandom_range(0, 18'h3FFFF));
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin : rsp_side
      int n;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (holds_served < hold_requests) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end
         n = idle_cycles();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("** goertzel_tone_magnitude_top: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int ph;
      int k;
      int phase_items;
      int len;
      bit phase_quiet;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-sample blocks at the extremes, alternating full scale,
      // one tone period at 45 degrees, and a run of negative full scale
      load_coefficients(fb_setting[3], cos_setting[3], sin_setting[3], 1'b1);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h0000, 1'b1);
      for (k = 0; k < 4; k++)
         send_sample((k % 2) ? 16'h8000 : 16'h7FFF, k == 3);
      for (k = 0; k < 8; k++)
         send_sample(tone_wave[k], k == 7);
      for (k = 0; k < 4; k++)
         send_sample(16'h8000, k == 3);
      drain(SETTLE_CYCLES);

      for (ph = 0; ph < NUM_SETTINGS; ph++) begin
         if (ph > 3) begin
            fb_setting[ph] = $urandom_range(0, 18'h3FFFF);
            cos_setting[ph] = $urandom_range(0, 18'h3FFFF);
            sin_setting[ph] = $urandom_range(0, 18'h3FFFF);
         end
         load_coefficients(fb_setting[ph], cos_setting[ph], sin_setting[ph], 1'b0);
         phase_quiet = ($urandom_range(0, 3) == 0);
         phase_items = 0;
         if (ph == HOLD_SETTING) begin
            hold_requests++;
            quiet = 1'b1;
            for (k = 0; k < 24; k++) begin
               len = $urandom_range(1, 2);
               send_random_block(len);
               phase_items += len;
            end
         end
         quiet = phase_quiet;
         while (phase_items < ITEMS_PER_PHASE) begin
            len = block_length();
            send_random_block(len);
            phase_items += len;
            if ($urandom_range(0, 19) == 0)
               drain(0);
         end
         quiet = 1'b0;
         drain(SETTLE_CYCLES);
      end

      // resonant full-scale block with coefficients at -2.0: the state grows on both signs
      quiet = 1'b1;
      load_coefficients(COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
      for (k = 0; k < LONG_BLOCK_LEN; k++)
         send_sample((k % 2) ? 16'h8000 : 16'h7FFF, k == LONG_BLOCK_LEN - 1);
      quiet = 1'b0;
      drain(SETTLE_CYCLES);

      $display("Sent %0d samples (%0d random) in %0d blocks over %0d coefficient settings,",
               samples_sent, random_samples, blocks_sent, settings_used);
      $display("checked %0d magnitudes, incl. a %0d-cycle result hold-off and a resonant block.",
               magnitudes_checked, HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("** goertzel_tone_magnitude_top: PASSED **");
      else
         $display("** goertzel_tone_magnitude_top: FAILED **");
      $finish;
   end

endmodule
